// ===== sv/rgba_ob_pkg.sv =====
// ----------------------------------------------------------------------------
// rgba_ob_pkg
// Types and constants shared by the RGBA "over" compositing pipeline.
// ----------------------------------------------------------------------------
package rgba_ob_pkg;

  // Channel full scale
  localparam logic [7:0] CH_MAX     = 8'hFF;
  // Division lanes: blue, green, red, then the output alpha
  localparam int         LANES      = 4;
  localparam int         ALPHA_LANE = 3;
  // One quotient bit per divider cell
  localparam int         STEPS      = 8;
  // Two multiply stages ahead of the divider chain
  localparam int         PREP_DEPTH = 2;
  localparam int         LATENCY    = PREP_DEPTH + STEPS;

  // Input transfer: a top and a bottom colour, R,G,B,A from high byte to low
  typedef struct packed {
    logic [31:0] top_color;
    logic [31:0] bottom_color;
  } blend_in_t;

  // Output transfer
  typedef struct packed {
    logic [31:0] out_color;
    logic        out_valid;
  } blend_out_t;

  // Data handed from one divider cell to the next
  typedef struct packed {
    logic                        vld;  // stage holds an item
    logic                        nz;   // combined alpha is nonzero
    logic [LANES-1:0][15:0]      rem;  // partial remainder, below the divisor
    logic [LANES-1:0][15:0]      div;  // divisor
    logic [LANES-1:0][7:0]       low;  // dividend bits still to bring down
    logic [LANES-1:0][7:0]       quo;  // quotient bits so far
  } div_stage_t;

endpackage

// ===== sv/rgba_over_blend.sv =====
// ----------------------------------------------------------------------------
// rgba_over_blend
// Porter-Duff "over" compositing of two non-premultiplied RGBA8888 colours.
// ----------------------------------------------------------------------------
// Takes one colour pair in every cycle (busy is always low) and returns each
// blended pixel on a one-cycle done strobe after the multiply stages and the
// divider chain; results come out in order and cannot be held off, so the
// receiver must take them when they appear. The pipeline is two multiply
// stages followed by a chain of eight divider cells, each resolving one
// quotient bit of the three colour channels and of the output alpha. When
// both alphas are zero the result is all zeros with out_valid low.
module rgba_over_blend
  import rgba_ob_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  blend_in_t  operands,
  output logic       done,
  output blend_out_t result
);

  div_stage_t chain [0:STEPS];

  // Never stalls
  assign busy = 1'b0;

  rgba_ob_prep u_prep (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .operands (operands),
    .head     (chain[0])
  );

  // Divider cells, one quotient bit each
  for (genvar i = 0; i < STEPS; i++) begin : g_cell
    rgba_ob_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .prev (chain[i]),
      .next (chain[i+1])
    );
  end

  // Pack the result, dropping it to zero when the weight was zero
  always_comb begin
    done = chain[STEPS].vld;
    if (chain[STEPS].nz) begin
      result.out_color = {chain[STEPS].quo[2], chain[STEPS].quo[1],
                          chain[STEPS].quo[0], chain[STEPS].quo[ALPHA_LANE]};
      result.out_valid = 1'b1;
    end else begin
      result.out_color = '0;
      result.out_valid = 1'b0;
    end
  end

  a_latency: assert property (@(posedge clk) disable iff (rst)
    start |-> ##LATENCY done)
    else $error("transfer did not complete after the pipeline latency");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LATENCY))
    else $error("result without a matching start");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    done && !result.out_valid |-> result.out_color == 32'd0)
    else $error("invalid result carries a colour");

  a_alpha_nonzero: assert property (@(posedge clk) disable iff (rst)
    done && result.out_valid |-> result.out_color[7:0] != 8'd0)
    else $error("valid result with zero alpha");

endmodule

// ===== sv/rgba_ob_prep.sv =====
// ----------------------------------------------------------------------------
// rgba_ob_prep
// Two multiply stages: form the per-channel numerators and the combined alpha
// weight, and load them as the first entry of the divider chain.
// ----------------------------------------------------------------------------
module rgba_ob_prep
  import rgba_ob_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  blend_in_t  operands,
  output div_stage_t head
);

  // First stage registers
  logic                   s1_vld;
  logic [2:0][15:0]       pa;     // ct * at
  logic [2:0][15:0]       pb;     // cb * ab
  logic [7:0]             inv;    // 255 - at
  logic [15:0]            m;      // ab * (255 - at)
  logic [7:0]             at;

  logic [7:0]             at_in;
  logic [7:0]             ab_in;
  logic [7:0]             inv_in;

  assign at_in  = operands.top_color[7:0];
  assign ab_in  = operands.bottom_color[7:0];
  assign inv_in = CH_MAX - at_in;

  // Valid flag of the first stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else begin
      s1_vld <= start;
    end
  end

  // Multiply colour channels by their alphas
  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      pa[c] <= 16'(operands.top_color[8*c+8 +: 8] * at_in);
      pb[c] <= 16'(operands.bottom_color[8*c+8 +: 8] * ab_in);
    end
    inv <= inv_in;
    m   <= 16'(ab_in * inv_in);
    at  <= at_in;
  end

  // Second stage: numerators and combined weight
  logic [2:0][23:0] num;
  logic [16:0]      aa_wide;
  logic [15:0]      aa;
  div_stage_t       head_next;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      num[c] = ({pa[c], 8'd0} - {8'd0, pa[c]}) + 24'(pb[c] * inv);
    end
    aa_wide = 17'(m) + ({1'b0, at, 8'd0} - 17'(at));
    aa      = aa_wide[15:0];

    head_next.vld = s1_vld;
    head_next.nz  = (aa != 16'd0);
    // Colour lanes divide by the combined weight
    for (int c = 0; c < 3; c++) begin
      head_next.rem[c] = num[c][23:8];
      head_next.low[c] = num[c][7:0];
      head_next.div[c] = aa;
      head_next.quo[c] = 8'd0;
    end
    // Alpha lane divides the combined weight by full scale
    head_next.rem[ALPHA_LANE] = {8'd0, aa[15:8]};
    head_next.low[ALPHA_LANE] = aa[7:0];
    head_next.div[ALPHA_LANE] = {8'd0, CH_MAX};
    head_next.quo[ALPHA_LANE] = 8'd0;
  end

  // Load the chain entry; only the valid flag is reset
  always_ff @(posedge clk) begin
    if (rst) begin
      head.vld <= 1'b0;
    end else begin
      head.vld <= head_next.vld;
    end
    head.nz  <= head_next.nz;
    head.rem <= head_next.rem;
    head.div <= head_next.div;
    head.low <= head_next.low;
    head.quo <= head_next.quo;
  end

endmodule

// ===== sv/rgba_ob_cell.sv =====
// ----------------------------------------------------------------------------
// rgba_ob_cell
// One restoring division step on all four lanes: bring down one dividend bit,
// subtract the divisor where it fits, shift in one quotient bit.
// ----------------------------------------------------------------------------
module rgba_ob_cell
  import rgba_ob_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  div_stage_t prev,
  output div_stage_t next
);

  div_stage_t  step;
  logic [16:0] trial;
  logic [16:0] diff;

  // Trial subtract on each lane
  always_comb begin
    step     = prev;
    trial    = '0;
    diff     = '0;
    for (int l = 0; l < LANES; l++) begin
      trial = {prev.rem[l], prev.low[l][7]};
      diff  = trial - {1'b0, prev.div[l]};
      if (trial >= {1'b0, prev.div[l]}) begin
        step.rem[l] = diff[15:0];
        step.quo[l] = {prev.quo[l][6:0], 1'b1};
      end else begin
        step.rem[l] = trial[15:0];
        step.quo[l] = {prev.quo[l][6:0], 1'b0};
      end
      step.low[l] = {prev.low[l][6:0], 1'b0};
    end
  end

  // Advance the stage; only the valid flag is reset
  always_ff @(posedge clk) begin
    if (rst) begin
      next.vld <= 1'b0;
    end else begin
      next.vld <= step.vld;
    end
    next.nz  <= step.nz;
    next.rem <= step.rem;
    next.div <= step.div;
    next.low <= step.low;
    next.quo <= step.quo;
  end

  // Colour remainders stay below their divisors whenever the weight is nonzero; the alpha remainder always does
  a_rem_colour: assert property (@(posedge clk) disable iff (rst)
    next.vld && next.nz |-> next.rem[0] < next.div[0] && next.rem[1] < next.div[1]
                            && next.rem[2] < next.div[2])
    else $error("colour remainder not below divisor");

  a_rem_alpha: assert property (@(posedge clk) disable iff (rst)
    next.vld |-> next.rem[ALPHA_LANE] < next.div[ALPHA_LANE])
    else $error("alpha remainder not below divisor");

  a_div_hold: assert property (@(posedge clk) disable iff (rst)
    $past(prev.vld) && next.vld |-> next.div == $past(prev.div))
    else $error("divisor changed along the chain");

endmodule
